@@ rtl/pls_pkg.sv @@
package pls_pkg;

	localparam int unsigned CapacityDefault = 64;

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_DELETE = 3'd1;
	localparam logic [2:0] OP_GET    = 3'd2;
	localparam logic [2:0] OP_LOCATE = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_BAD_POS  = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [2:0]         op;
		logic [6:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] read_value;
		logic [6:0]         found_position;
		logic [6:0]         count;
		logic               empty_res;
	} rsp_t;

endpackage

@@ rtl/pls_stream_if.sv @@
interface pls_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

@@ rtl/positional_list_store.sv @@
// Ordered list of signed 32-bit values addressed by 1-based positions.
// The req channel carries one operation per transfer (insert, delete, get,
// locate or clear); the rsp channel returns exactly one result per request,
// in order, with status, read value, found position and the count after the
// operation. A request is taken only while no earlier request is in work,
// but a finished result may still wait in the output register.
// The entries live in one synchronous memory with one read and one write
// port, so every walk steps over one entry per cycle. Clear, rejected
// requests and append go straight to the result; get, insert, delete and
// locate walk the memory, then drain the last read, and insert then writes
// the new value before the result; locate stops at the first match.
// A new request is taken only once the walk of the last one is over and
// its result has been placed in the output register.
// Reset clears the element count and the control state; the memory is not
// cleared, since only positions below the count are ever read.
// When the receiver stalls the result stays in the output register and the
// block finishes the next request, holding its result until the register
// frees up.
module positional_list_store #(
	parameter int unsigned CAPACITY = pls_pkg::CapacityDefault
) (
	input logic clk,
	input logic arst_n,
	pls_stream_if.sink   req,
	pls_stream_if.source rsp
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned LW = $clog2(CAPACITY + 1);
	localparam int unsigned CW = ((LW > 7) ? LW : 7) + 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WALK  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_PUT   = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]         state_q;
	logic [LW-1:0]      len_q;
	logic [2:0]         op_q;
	logic signed [31:0] val_q;
	logic [AW-1:0]      idx_q;
	logic [AW-1:0]      last_q;
	logic [AW-1:0]      first_q;
	logic               rd_vld_s1;
	logic [AW-1:0]      rd_addr_s1;
	logic signed [31:0] rdata_s1;
	logic [1:0]         res_status_q;
	logic signed [31:0] res_rd_q;
	logic [6:0]         res_found_q;
	logic               out_vld_q;
	pls_pkg::rsp_t      out_q;

	logic signed [31:0] mem_q [CAPACITY];

	logic               accept;
	logic [CW-1:0]      pos_ext;
	logic [CW-1:0]      len_ext;
	logic [AW-1:0]      pos_addr;
	logic               match;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic signed [31:0] mem_wd;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign pos_ext   = CW'(req.payload.position);
	assign len_ext   = CW'(len_q);
	assign pos_addr  = AW'(pos_ext - CW'(1));
	assign match     = rd_vld_s1 && (op_q == pls_pkg::OP_LOCATE) && (rdata_s1 == val_q);

	assign rsp.valid   = out_vld_q;
	assign rsp.payload = out_q;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = rd_addr_s1;
		mem_wd = rdata_s1;
		priority if (accept && req.payload.op == pls_pkg::OP_INSERT
				&& len_ext < CW'(CAPACITY) && pos_ext == len_ext + CW'(1)) begin
			mem_we = 1'b1;
			mem_wa = AW'(len_q);
			mem_wd = req.payload.value;
		end else if (state_q == S_PUT) begin
			mem_we = 1'b1;
			mem_wa = first_q;
			mem_wd = val_q;
		end else if (rd_vld_s1 && op_q == pls_pkg::OP_INSERT) begin
			mem_we = 1'b1;
			mem_wa = rd_addr_s1 + AW'(1);
		end else if (rd_vld_s1 && op_q == pls_pkg::OP_DELETE && rd_addr_s1 != first_q) begin
			mem_we = 1'b1;
			mem_wa = rd_addr_s1 - AW'(1);
		end else begin
			mem_we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rdata_s1 <= mem_q[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			len_q        <= '0;
			op_q         <= '0;
			val_q        <= '0;
			idx_q        <= '0;
			last_q       <= '0;
			first_q      <= '0;
			rd_vld_s1    <= 1'b0;
			rd_addr_s1   <= '0;
			res_status_q <= pls_pkg::ST_OK;
			res_rd_q     <= '0;
			res_found_q  <= '0;
			out_vld_q    <= 1'b0;
			out_q        <= '0;
		end else begin
			if (out_vld_q && rsp.ready && state_q != S_DONE) begin
				out_vld_q <= 1'b0;
			end
			if (rd_vld_s1 && rd_addr_s1 == first_q
					&& (op_q == pls_pkg::OP_GET || op_q == pls_pkg::OP_DELETE)) begin
				res_rd_q <= rdata_s1;
			end
			unique case (state_q)
				S_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (accept) begin
						op_q         <= req.payload.op;
						val_q        <= req.payload.value;
						first_q      <= pos_addr;
						res_status_q <= pls_pkg::ST_OK;
						res_rd_q     <= '0;
						res_found_q  <= '0;
						state_q      <= S_DONE;
						unique case (req.payload.op)
							pls_pkg::OP_INSERT: begin
								priority if (len_ext >= CW'(CAPACITY)) begin
									res_status_q <= pls_pkg::ST_FULL;
								end else if (pos_ext == '0 || pos_ext > len_ext + CW'(1)) begin
									res_status_q <= pls_pkg::ST_BAD_POS;
								end else begin
									len_q <= len_q + LW'(1);
									if (pos_ext != len_ext + CW'(1)) begin
										idx_q   <= AW'(len_q - LW'(1));
										last_q  <= pos_addr;
										state_q <= S_WALK;
									end
								end
							end
							pls_pkg::OP_DELETE, pls_pkg::OP_GET: begin
								if (pos_ext == '0 || pos_ext > len_ext) begin
									res_status_q <= pls_pkg::ST_BAD_POS;
								end else begin
									idx_q   <= pos_addr;
									state_q <= S_WALK;
									if (req.payload.op == pls_pkg::OP_DELETE) begin
										last_q <= AW'(len_q - LW'(1));
										len_q  <= len_q - LW'(1);
									end else begin
										last_q <= pos_addr;
									end
								end
							end
							pls_pkg::OP_LOCATE: begin
								res_status_q <= pls_pkg::ST_NOTFOUND;
								if (len_q != '0) begin
									idx_q   <= '0;
									last_q  <= AW'(len_q - LW'(1));
									state_q <= S_WALK;
								end
							end
							pls_pkg::OP_CLEAR: begin
								len_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_WALK: begin
					if (match) begin
						res_status_q <= pls_pkg::ST_OK;
						res_found_q  <= 7'(rd_addr_s1) + 7'd1;
						rd_vld_s1    <= 1'b0;
						state_q      <= S_DONE;
					end else begin
						rd_vld_s1  <= 1'b1;
						rd_addr_s1 <= idx_q;
						if (idx_q == last_q) begin
							state_q <= S_DRAIN;
						end else if (op_q == pls_pkg::OP_INSERT) begin
							idx_q <= idx_q - AW'(1);
						end else begin
							idx_q <= idx_q + AW'(1);
						end
					end
				end
				S_DRAIN: begin
					rd_vld_s1 <= 1'b0;
					if (match) begin
						res_status_q <= pls_pkg::ST_OK;
						res_found_q  <= 7'(rd_addr_s1) + 7'd1;
					end
					state_q <= (op_q == pls_pkg::OP_INSERT) ? S_PUT : S_DONE;
				end
				S_PUT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_vld_q || rsp.ready) begin
						out_vld_q            <= 1'b1;
						out_q.status         <= res_status_q;
						out_q.read_value     <= res_rd_q;
						out_q.found_position <= res_found_q;
						out_q.count          <= 7'(len_q);
						out_q.empty_res      <= (len_q == '0);
						state_q              <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
